// File: src/serpent_pkg.sv
// ----------------------------------------------------------------------------
// Serpent cipher package
// Round constants, S-box tables, bit permutations and the linear transform.
// ----------------------------------------------------------------------------
package serpent_pkg;

  localparam int unsigned KeyCount = 33;
  localparam logic [31:0] Phi      = 32'h9e3779b9;

  typedef enum logic [2:0] {
    CfgKeySize = 3'd0,
    CfgKey01   = 3'd1,
    CfgKey23   = 3'd2,
    CfgKey45   = 3'd3,
    CfgKey67   = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    OpEncrypt = 1'b0,
    OpDecrypt = 1'b1
  } cipher_op_e;

  localparam logic [1:0] KeySz128 = 2'd0;
  localparam logic [1:0] KeySz192 = 2'd1;

  typedef logic [3:0] nib_t;

  typedef nib_t sbox_row_t [16];
  typedef sbox_row_t sbox_tab_t [8];

  localparam sbox_tab_t SboxFwd = '{
    '{4'd3, 4'd8, 4'd15, 4'd1, 4'd10, 4'd6, 4'd5, 4'd11,
      4'd14, 4'd13, 4'd4, 4'd2, 4'd7, 4'd0, 4'd9, 4'd12},
    '{4'd15, 4'd12, 4'd2, 4'd7, 4'd9, 4'd0, 4'd5, 4'd10,
      4'd1, 4'd11, 4'd14, 4'd8, 4'd6, 4'd13, 4'd3, 4'd4},
    '{4'd8, 4'd6, 4'd7, 4'd9, 4'd3, 4'd12, 4'd10, 4'd15,
      4'd13, 4'd1, 4'd14, 4'd4, 4'd0, 4'd11, 4'd5, 4'd2},
    '{4'd0, 4'd15, 4'd11, 4'd8, 4'd12, 4'd9, 4'd6, 4'd3,
      4'd13, 4'd1, 4'd2, 4'd4, 4'd10, 4'd7, 4'd5, 4'd14},
    '{4'd1, 4'd15, 4'd8, 4'd3, 4'd12, 4'd0, 4'd11, 4'd6,
      4'd2, 4'd5, 4'd4, 4'd10, 4'd9, 4'd14, 4'd7, 4'd13},
    '{4'd15, 4'd5, 4'd2, 4'd11, 4'd4, 4'd10, 4'd9, 4'd12,
      4'd0, 4'd3, 4'd14, 4'd8, 4'd13, 4'd6, 4'd7, 4'd1},
    '{4'd7, 4'd2, 4'd12, 4'd5, 4'd8, 4'd4, 4'd6, 4'd11,
      4'd14, 4'd9, 4'd1, 4'd15, 4'd13, 4'd3, 4'd10, 4'd0},
    '{4'd1, 4'd13, 4'd15, 4'd0, 4'd14, 4'd8, 4'd2, 4'd11,
      4'd7, 4'd4, 4'd12, 4'd10, 4'd9, 4'd3, 4'd5, 4'd6}
  };

  localparam sbox_tab_t SboxInv = '{
    '{4'd13, 4'd3, 4'd11, 4'd0, 4'd10, 4'd6, 4'd5, 4'd12,
      4'd1, 4'd14, 4'd4, 4'd7, 4'd15, 4'd9, 4'd8, 4'd2},
    '{4'd5, 4'd8, 4'd2, 4'd14, 4'd15, 4'd6, 4'd12, 4'd3,
      4'd11, 4'd4, 4'd7, 4'd9, 4'd1, 4'd13, 4'd10, 4'd0},
    '{4'd12, 4'd9, 4'd15, 4'd4, 4'd11, 4'd14, 4'd1, 4'd2,
      4'd0, 4'd3, 4'd6, 4'd13, 4'd5, 4'd8, 4'd10, 4'd7},
    '{4'd0, 4'd9, 4'd10, 4'd7, 4'd11, 4'd14, 4'd6, 4'd13,
      4'd3, 4'd5, 4'd12, 4'd2, 4'd4, 4'd8, 4'd15, 4'd1},
    '{4'd5, 4'd0, 4'd8, 4'd3, 4'd10, 4'd9, 4'd7, 4'd14,
      4'd2, 4'd12, 4'd11, 4'd6, 4'd4, 4'd15, 4'd13, 4'd1},
    '{4'd8, 4'd15, 4'd2, 4'd9, 4'd4, 4'd1, 4'd13, 4'd14,
      4'd11, 4'd6, 4'd5, 4'd3, 4'd7, 4'd12, 4'd10, 4'd0},
    '{4'd15, 4'd10, 4'd1, 4'd13, 4'd5, 4'd3, 4'd6, 4'd0,
      4'd4, 4'd9, 4'd14, 4'd7, 4'd2, 4'd12, 4'd8, 4'd11},
    '{4'd3, 4'd0, 4'd6, 4'd13, 4'd9, 4'd14, 4'd15, 4'd8,
      4'd5, 4'd12, 4'd11, 4'd7, 4'd10, 4'd1, 4'd4, 4'd2}
  };

  // out bit i = in bit 32*(i mod 4) + i/4
  function automatic logic [127:0] perm_ip(input logic [127:0] x);
    logic [127:0] y;
    for (int i = 0; i < 128; i++) begin
      y[i] = x[(i % 4) * 32 + i / 4];
    end
    return y;
  endfunction

  // out bit i = in bit 4*(i mod 32) + i/32
  function automatic logic [127:0] perm_fp(input logic [127:0] x);
    logic [127:0] y;
    for (int i = 0; i < 128; i++) begin
      y[i] = x[(i % 32) * 4 + i / 32];
    end
    return y;
  endfunction

  function automatic logic [127:0] sbox_layer(input logic [127:0] x, input logic [2:0] box,
                                              input logic inv);
    logic [127:0] y;
    for (int j = 0; j < 32; j++) begin
      y[4*j +: 4] = inv ? SboxInv[box][x[4*j +: 4]] : SboxFwd[box][x[4*j +: 4]];
    end
    return y;
  endfunction

  // bitslice S-box: nibble j gathers bit j of each word
  function automatic logic [127:0] sbox_slice(input logic [127:0] p, input logic [2:0] box);
    logic [127:0] y;
    nib_t         n;
    nib_t         o;
    for (int j = 0; j < 32; j++) begin
      n = {p[96+j], p[64+j], p[32+j], p[j]};
      o = SboxFwd[box][n];
      y[j]    = o[0];
      y[32+j] = o[1];
      y[64+j] = o[2];
      y[96+j] = o[3];
    end
    return y;
  endfunction

  function automatic logic [31:0] rol(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic logic [127:0] lin_fwd(input logic [127:0] b);
    logic [127:0] v;
    logic [31:0]  x0, x1, x2, x3;
    v  = perm_fp(b);
    x0 = rol(v[31:0], 13);
    x2 = rol(v[95:64], 3);
    x1 = v[63:32] ^ x0 ^ x2;
    x3 = v[127:96] ^ x2 ^ (x0 << 3);
    x1 = rol(x1, 1);
    x3 = rol(x3, 7);
    x0 = x0 ^ x1 ^ x3;
    x2 = x2 ^ x3 ^ (x1 << 7);
    x0 = rol(x0, 5);
    x2 = rol(x2, 22);
    return perm_ip({x3, x2, x1, x0});
  endfunction

  function automatic logic [127:0] lin_inv(input logic [127:0] b);
    logic [127:0] v;
    logic [31:0]  x0, x1, x2, x3;
    v  = perm_fp(b);
    x0 = rol(v[31:0], 27);
    x2 = rol(v[95:64], 10);
    x1 = v[63:32];
    x3 = v[127:96];
    x2 = x2 ^ x3 ^ (x1 << 7);
    x0 = x0 ^ x1 ^ x3;
    x3 = rol(x3, 25);
    x1 = rol(x1, 31);
    x3 = x3 ^ x2 ^ (x0 << 3);
    x1 = x1 ^ x0 ^ x2;
    x2 = rol(x2, 29);
    x0 = rol(x0, 19);
    return perm_ip({x3, x2, x1, x0});
  endfunction

endpackage

// File: src/serpent_block_cipher_top.sv
// The first block after a key write first runs key expansion (one prekey word a cycle);
// the output register lets the next block run while a result waits, and the round unit
// holds in its output step until the register frees.
// Reset clears control, key registers and datapath; the round key memory is filled before use.
// ----------------------------------------------------------------------------
// Serpent block cipher top
// Key schedule sequencer, round key memory and a shared single-round unit.
// ----------------------------------------------------------------------------
module serpent_block_cipher_top import serpent_pkg::*; #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // block_low, block_high
  input  logic         s_axis_tuser,  // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata   // out_low, out_high
);

  localparam int unsigned RW = $clog2(ROUND_COUNT + 1);
  localparam int unsigned KW = $clog2(KeyCount);

  typedef enum logic [4:0] {
    StIdle = 5'b00001, StPre = 5'b00010, StLoad = 5'b00100,
    StRnd  = 5'b01000, StOut = 5'b10000
  } state_e;

  state_e        st_q, st_d;
  logic [1:0]    ksz_q;
  logic [63:0]   kreg_q [4];
  logic          ready_q;
  logic [255:0]  win_q;        // last eight prekey words
  logic [7:0]    wcnt_q;       // prekey index i-8
  logic [1:0]    wsub_q;
  logic [95:0]   pk_q;         // first three words of the current round key
  logic [KW-1:0] kidx_q;       // round key being written
  logic [127:0]  rk_mem [KeyCount];
  logic [127:0]  rk_q;
  logic [RW-1:0] rnd_q;
  logic          dec_q;
  logic [127:0]  blk_q;
  logic [127:0]  res_q;
  logic          ov_q;
  logic [KW-1:0] rd_addr;
  logic          rd_en;
  logic          in_fire;
  logic          cfg_fire;
  logic          out_fire;
  logic          out_free;
  logic [31:0]   wnew;
  logic [127:0]  rk_new;
  logic [255:0]  kfull;
  logic [255:0]  kpad;
  logic          top_rnd;
  logic          last_rnd;
  logic [127:0]  mixed;
  logic [127:0]  enc_sb;
  logic [127:0]  rnd_res;

  assign cfg_ready_o   = (st_q == StIdle);
  assign s_axis_tready = (st_q == StIdle) && !cfg_valid_i;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = res_q;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign out_free = !ov_q || m_axis_tready;

  // words at offsets -8, -5, -3, -1 sit in window lanes 0, 3, 5, 7
  assign wnew   = rol(win_q[31:0] ^ win_q[127:96] ^ win_q[191:160] ^ win_q[255:224] ^ Phi ^
                      {24'd0, wcnt_q}, 11);
  assign rk_new = perm_ip(sbox_slice({wnew, pk_q}, 3'd3 - kidx_q[2:0]));

  assign kfull = {kreg_q[3], kreg_q[2], kreg_q[1], kreg_q[0]};
  always_comb begin
    unique case (ksz_q)
      KeySz128: kpad = {128'd0, kfull[127:0]} | {127'd0, 1'b1, 128'd0};
      KeySz192: kpad = {64'd0, kfull[191:0]} | {63'd0, 1'b1, 192'd0};
      default:  kpad = kfull;
    endcase
  end

  assign top_rnd  = (rnd_q == RW'(ROUND_COUNT - 1));
  assign last_rnd = dec_q ? (rnd_q == '0) : top_rnd;
  assign mixed    = blk_q ^ rk_q;
  assign enc_sb   = sbox_layer(mixed, rnd_q[2:0], 1'b0);

  // decrypt round: mix key r+1, undo the linear layer except on the first pass, inverse S-box
  always_comb begin
    if (dec_q) begin
      rnd_res = sbox_layer(top_rnd ? mixed : lin_inv(mixed), rnd_q[2:0], 1'b1);
    end else begin
      rnd_res = top_rnd ? enc_sb : lin_fwd(enc_sb);
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (in_fire) st_d = ready_q ? StLoad : StPre;
      StPre:  if (wsub_q == 2'd3 && kidx_q == KW'(KeyCount - 1)) st_d = StLoad;
      StLoad: st_d = StRnd;
      StRnd:  if (last_rnd) st_d = StOut;
      StOut:  if (out_free) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // fetch the key for the next step: encrypt uses key r, decrypt key r+1, then the final key
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (st_q == StLoad) begin
      rd_en   = 1'b1;
      rd_addr = dec_q ? KW'(ROUND_COUNT) : '0;
    end else if (st_q == StRnd) begin
      rd_en   = 1'b1;
      rd_addr = dec_q ? KW'(rnd_q) : KW'(rnd_q + RW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StPre && wsub_q == 2'd3) rk_mem[kidx_q] <= rk_new;
    if (rd_en) rk_q <= rk_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ksz_q <= '0; ready_q <= 1'b0; ov_q <= 1'b0;
      for (int i = 0; i < 4; i++) kreg_q[i] <= '0;
      win_q <= '0; pk_q <= '0;
      wcnt_q <= '0; wsub_q <= '0; kidx_q <= '0; rnd_q <= '0; dec_q <= 1'b0;
      blk_q <= '0; res_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_fire) begin
        unique case (cfg_index_i)
          CfgKeySize: begin
            ksz_q   <= cfg_data_i[1:0];
            ready_q <= 1'b0;
          end
          CfgKey01, CfgKey23, CfgKey45, CfgKey67: begin
            kreg_q[cfg_index_i[1:0] - 2'd1] <= cfg_data_i;
            ready_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (st_q == StOut && out_free) ov_q <= 1'b1;
      else if (out_fire) ov_q <= 1'b0;
      unique case (st_q)
        StIdle: if (in_fire) begin
          dec_q  <= (s_axis_tuser == OpDecrypt);
          blk_q  <= perm_ip(s_axis_tdata);
          win_q  <= kpad;
          wcnt_q <= '0; wsub_q <= '0; kidx_q <= '0;
          rnd_q  <= (s_axis_tuser == OpDecrypt) ? RW'(ROUND_COUNT - 1) : '0;
        end
        StPre: begin
          win_q  <= {wnew, win_q[255:32]};
          pk_q   <= {wnew, pk_q[95:32]};
          wcnt_q <= wcnt_q + 8'd1;
          wsub_q <= wsub_q + 2'd1;
          if (wsub_q == 2'd3) kidx_q <= kidx_q + KW'(1);
          if (st_d == StLoad) ready_q <= 1'b1;
        end
        StLoad: ;
        StRnd: begin
          blk_q <= rnd_res;
          rnd_q <= dec_q ? rnd_q - RW'(1) : rnd_q + RW'(1);
        end
        StOut: if (out_free) begin
          res_q <= perm_fp(mixed);
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q)) else $error("state not one-hot");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> (!s_axis_tready && !cfg_ready_o)) else $error("accepted while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result beat dropped or changed");
  a_key:  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StRnd) |-> ready_q) else $error("rounds without keys");
`endif

endmodule

// File: tb/serpent_block_cipher_top_tb.sv
// ----------------------------------------------------------------------------
// Serpent block cipher testbench
// Streams encrypt and decrypt blocks through the cipher under several keys and
// key sizes, predicts each block with a local Serpent model and checks every
// result beat in order, with random idles on both sides and one long
// output stall.
// ----------------------------------------------------------------------------
module serpent_block_cipher_top_tb;
  import serpent_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Rounds = 32;

  // nibble tables kept locally so the prediction does not reuse the package
  localparam int FwdTab [8][16] = '{
    '{ 3,  8, 15,  1, 10,  6,  5, 11, 14, 13,  4,  2,  7,  0,  9, 12},
    '{15, 12,  2,  7,  9,  0,  5, 10,  1, 11, 14,  8,  6, 13,  3,  4},
    '{ 8,  6,  7,  9,  3, 12, 10, 15, 13,  1, 14,  4,  0, 11,  5,  2},
    '{ 0, 15, 11,  8, 12,  9,  6,  3, 13,  1,  2,  4, 10,  7,  5, 14},
    '{ 1, 15,  8,  3, 12,  0, 11,  6,  2,  5,  4, 10,  9, 14,  7, 13},
    '{15,  5,  2, 11,  4, 10,  9, 12,  0,  3, 14,  8, 13,  6,  7,  1},
    '{ 7,  2, 12,  5,  8,  4,  6, 11, 14,  9,  1, 15, 13,  3, 10,  0},
    '{ 1, 13, 15,  0, 14,  8,  2, 11,  7,  4, 12, 10,  9,  3,  5,  6}
  };
  localparam int InvTab [8][16] = '{
    '{13,  3, 11,  0, 10,  6,  5, 12,  1, 14,  4,  7, 15,  9,  8,  2},
    '{ 5,  8,  2, 14, 15,  6, 12,  3, 11,  4,  7,  9,  1, 13, 10,  0},
    '{12,  9, 15,  4, 11, 14,  1,  2,  0,  3,  6, 13,  5,  8, 10,  7},
    '{ 0,  9, 10,  7, 11, 14,  6, 13,  3,  5, 12,  2,  4,  8, 15,  1},
    '{ 5,  0,  8,  3, 10,  9,  7, 14,  2, 12, 11,  6,  4, 15, 13,  1},
    '{ 8, 15,  2,  9,  4,  1, 13, 14, 11,  6,  5,  3,  7, 12, 10,  0},
    '{15, 10,  1, 13,  5,  3,  6,  0,  4,  9, 14,  7,  2, 12,  8, 11},
    '{ 3,  0,  6, 13,  9, 14, 15,  8,  5, 12, 11,  7, 10,  1,  4,  2}
  };

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [63:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;  // block_low, block_high
  logic         s_axis_tuser = 1'b0;  // opcode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;  // out_low, out_high

  serpent_block_cipher_top #(.ROUND_COUNT(Rounds)) dut (.*);

  always #6 clk_i = ~clk_i;

  function automatic logic [3:0] sb(input int box, input logic [3:0] n, input bit inv);
    return inv ? 4'(InvTab[box][n]) : 4'(FwdTab[box][n]);
  endfunction

  function automatic logic [127:0] to_slice(input logic [127:0] x);
    logic [127:0] y;
    for (int i = 0; i < 128; i++) y[i] = x[(i % 4) * 32 + i / 4];
    return y;
  endfunction

  function automatic logic [127:0] from_slice(input logic [127:0] x);
    logic [127:0] y;
    for (int i = 0; i < 128; i++) y[i] = x[(i % 32) * 4 + i / 32];
    return y;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
    return (s == 0) ? x : ((x << s) | (x >> (32 - s)));
  endfunction

  function automatic logic [127:0] subst(input logic [127:0] x, input int box, input bit inv);
    logic [127:0] y;
    for (int j = 0; j < 32; j++) y[4*j +: 4] = sb(box % 8, x[4*j +: 4], inv);
    return y;
  endfunction

  function automatic logic [127:0] mix_fwd(input logic [127:0] b);
    logic [127:0] v;
    logic [31:0]  a0, a1, a2, a3;
    v  = from_slice(b);
    a0 = rotl(v[31:0], 13);
    a2 = rotl(v[95:64], 3);
    a1 = v[63:32] ^ a0 ^ a2;
    a3 = v[127:96] ^ a2 ^ (a0 << 3);
    a1 = rotl(a1, 1);
    a3 = rotl(a3, 7);
    a0 = a0 ^ a1 ^ a3;
    a2 = a2 ^ a3 ^ (a1 << 7);
    return to_slice({a3, rotl(a2, 22), a1, rotl(a0, 5)});
  endfunction

  function automatic logic [127:0] mix_inv(input logic [127:0] b);
    logic [127:0] v;
    logic [31:0]  a0, a1, a2, a3;
    v  = from_slice(b);
    a0 = rotl(v[31:0], 27);
    a2 = rotl(v[95:64], 10);
    a1 = v[63:32];
    a3 = v[127:96];
    a2 = a2 ^ a3 ^ (a1 << 7);
    a0 = a0 ^ a1 ^ a3;
    a3 = rotl(a3, 25);
    a1 = rotl(a1, 31);
    a3 = a3 ^ a2 ^ (a0 << 3);
    a1 = a1 ^ a0 ^ a2;
    return to_slice({a3, rotl(a2, 29), a1, rotl(a0, 19)});
  endfunction

  class cipher_scoreboard;
    logic [1:0]   size_code = '0;
    logic [63:0]  key_word [4] = '{default: '0};
    logic [127:0] subkey [33];
    bit           subkeys_valid;
    logic [127:0] expected_q [$];
    int           mismatches;
    int           checked;
    int           enc_cnt;
    int           dec_cnt;

    function void write_reg(input cfg_reg_e idx, input logic [63:0] val);
      if (idx == CfgKeySize) size_code = val[1:0];
      else key_word[idx - 1] = val;
      subkeys_valid = 0;
    endfunction

    function void expand();
      logic [31:0] w [140];
      logic [31:0] p [4];
      logic [127:0] sk;
      logic [3:0]  n, o;
      int nw;
      nw = (size_code == KeySz128) ? 4 : (size_code == KeySz192) ? 6 : 8;
      for (int i = 0; i < 140; i++) w[i] = '0;
      for (int i = 0; i < nw; i++) w[i] = key_word[i / 2][32 * (i % 2) +: 32];
      if (nw < 8) w[nw] = 32'd1;
      for (int i = 8; i < 140; i++)
        w[i] = rotl(w[i-8] ^ w[i-5] ^ w[i-3] ^ w[i-1] ^ 32'h9e3779b9 ^ 32'(i - 8), 11);
      for (int k = 0; k < 33; k++) begin
        for (int l = 0; l < 4; l++) p[l] = w[8 + 4 * k + l];
        for (int j = 0; j < 32; j++) begin
          n = {p[3][j], p[2][j], p[1][j], p[0][j]};
          o = sb((35 - k) % 8, n, 0);
          for (int l = 0; l < 4; l++) sk[32 * l + j] = o[l];
        end
        subkey[k] = to_slice(sk);
      end
      subkeys_valid = 1;
    endfunction

    function void note_block(input cipher_op_e op, input logic [127:0] blk);
      logic [127:0] b;
      if (!subkeys_valid) expand();
      b = to_slice(blk);
      if (op == OpEncrypt) begin
        enc_cnt++;
        for (int r = 0; r < Rounds; r++) begin
          b = subst(b ^ subkey[r], r, 0);
          b = (r == Rounds - 1) ? b ^ subkey[r + 1] : mix_fwd(b);
        end
      end else begin
        dec_cnt++;
        for (int r = Rounds - 1; r >= 0; r--) begin
          b = (r == Rounds - 1) ? b ^ subkey[r + 1] : mix_inv(b);
          b = subst(b, r, 1) ^ subkey[r];
        end
      end
      expected_q.push_back(from_slice(b));
    endfunction

    function void check_result(input logic [127:0] got);
      logic [127:0] want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got[63:0] !== want[63:0] || got[127:64] !== want[127:64]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected high %h low %h, got high %h low %h", checked,
                   want[127:64], want[63:0], got[127:64], got[63:0]);
      end
    endfunction
  endclass

  cipher_scoreboard sbd = new();
  bit idle_en = 1;
  bit hold_out = 0;

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sbd.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_key(input logic [1:0] code, input logic [63:0] k0, k1, k2, k3);
    write_reg(CfgKeySize, 64'(code));
    write_reg(CfgKey01, k0);
    write_reg(CfgKey23, k1);
    write_reg(CfgKey45, k2);
    write_reg(CfgKey67, k3);
  endtask

  task automatic send_block(input cipher_op_e op, input logic [127:0] blk);
    @(negedge clk_i);
    while (idle_en && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= blk;
    do @(posedge clk_i); while (!s_axis_tready);
    sbd.note_block(op, blk);
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // drain before touching the key registers
  task automatic drain();
    end_burst();
    while (sbd.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [127:0] rand_block();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return {rand64(), rand64()};
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sbd.check_result(m_axis_tdata);
  end

  always @(negedge clk_i) begin
    m_axis_tready <= !hold_out && !(idle_en && $urandom_range(99) < 33);
  end

  initial begin
    #20ms;
    $display("serpent_block_cipher_top_tb: done, errors");
    $finish;
  end

  initial begin
    logic [127:0] blk;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // registers at reset: 128-bit all-zero key
    send_block(OpEncrypt, '0);
    send_block(OpDecrypt, '1);
    drain();
    load_key(2'd0, '1, '1, '0, '0);
    send_block(OpEncrypt, '1);
    send_block(OpDecrypt, '0);
    send_block(OpEncrypt, {64'h0, 64'h1});
    send_block(OpDecrypt, {64'h8000_0000_0000_0000, 64'h0});
    drain();
    load_key(2'd1, 64'h0123456789abcdef, 64'hfedcba9876543210, 64'hffffffffffffffff,
             64'h5a5a5a5a5a5a5a5a);
    send_block(OpEncrypt, '0);
    send_block(OpDecrypt, '1);
    drain();
    // 256-bit key, then size code three which behaves the same
    load_key(2'd2, '1, '1, '1, '1);
    send_block(OpEncrypt, '0);
    send_block(OpDecrypt, '0);
    drain();
    write_reg(CfgKeySize, 64'd3);
    send_block(OpEncrypt, '0);
    send_block(OpDecrypt, {64'h1, 64'h8000_0000_0000_0000});
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      load_key(2'(ph % 4), rand64(), rand64(), rand64(), rand64());
      idle_en = (ph != 2);
      for (int i = 0; i < 96; i++) begin
        if (ph == 4 && i == 10) begin
          fork
            begin
              hold_out = 1;
              repeat (400) @(posedge clk_i);
              hold_out = 0;
            end
          join_none
        end
        blk = rand_block();
        send_block(cipher_op_e'($urandom_range(1)), blk);
      end
      drain();
    end
    idle_en = 1;
    repeat (60) @(posedge clk_i);

    $display("covered %0d encrypt and %0d decrypt blocks, %0d results checked,",
             sbd.enc_cnt, sbd.dec_cnt, sbd.checked);
    $display("key sizes 128/192/256 and code three, with idles and a long output stall");
    if (sbd.mismatches == 0 && sbd.expected_q.size() == 0) begin
      $display("serpent_block_cipher_top_tb: done, clean");
    end else begin
      $display("serpent_block_cipher_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
src/serpent_pkg.sv
src/serpent_block_cipher_top.sv
tb/serpent_block_cipher_top_tb.sv
